### rtl/core/qfa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
package qfa_pkg;

    typedef enum logic [3:0] {
        ACT_ADD        = 4'd0,
        ACT_SUB        = 4'd1,
        ACT_MUL        = 4'd2,
        ACT_DIV        = 4'd3,
        ACT_MIN        = 4'd4,
        ACT_MAX        = 4'd5,
        ACT_INC        = 4'd6,
        ACT_DEC        = 4'd7,
        ACT_FROM_INT   = 4'd8,
        ACT_FROM_FLOAT = 4'd9,
        ACT_TO_INT     = 4'd10,
        ACT_TO_FLOAT   = 4'd11,
        ACT_COMPARE    = 4'd12
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_DIV_ZERO    = 2'd1,
        ST_FLOAT_RANGE = 2'd2
    } t_status;

    localparam int FLT_BIAS = 127;
    localparam int FLT_EXP_OFFSET = 150;
    localparam logic [7:0] FLT_EXP_SPECIAL = 8'hFF;
    localparam int F2X_BIG_SHIFT = 40;
    localparam int F2X_TINY_SHIFT = 25;

endpackage

### rtl/core/qfa_dly.sv
// Fixed-depth register line that aligns a unit's word with the common latency.
module qfa_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

### rtl/core/qfa_mul.sv
// Pipelined fixed-point multiplier with floor rescale.
module qfa_mul #(
    parameter int DW  = 32,
    parameter int FB  = 8,
    parameter int LAT = 43
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic        [DW-1:0] o_p
);

    localparam int OWN = 2;

    logic signed [2*DW-1:0] r_prod;
    logic        [DW-1:0]   r_sel;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        // floor shift then wrap: just a bit window of the product
        r_sel  <= r_prod[FB +: DW];
    end

    qfa_dly #(.WIDTH(DW), .DEPTH(LAT - OWN)) u_pad (
        .i_clk (i_clk),
        .i_d   (r_sel),
        .o_q   (o_p)
    );

endmodule

### rtl/core/qfa_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
module qfa_div #(
    parameter int DW  = 32,
    parameter int FB  = 8,
    parameter int LAT = 43
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic        [DW-1:0] o_q,
    output logic                 o_dz
);

    localparam int QW  = DW + FB;
    localparam int OWN = QW + 2;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_rq  [QW+1];
    logic [DW-1:0] r_d   [QW+1];
    logic          r_neg [QW+1];
    logic          r_dz  [QW+1];
    logic [DW-1:0] r_res;
    logic          r_res_dz;
    logic [DW-1:0] a_mag;
    logic [DW-1:0] b_mag;
    logic [DW-1:0] q_low;

    assign a_mag = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign b_mag = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_rq[0]  <= {a_mag, {FB{1'b0}}};
        r_d[0]   <= b_mag;
        r_neg[0] <= i_a[DW-1] ^ i_b[DW-1];
        r_dz[0]  <= (i_b == '0);
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0] t;
        logic        ge;

        always_comb begin
            t  = {r_rem[s], r_rq[s][QW-1]};
            ge = (t >= {1'b0, r_d[s]});
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= ge ? DW'(t - {1'b0, r_d[s]}) : t[DW-1:0];
            r_rq[s+1]  <= {r_rq[s][QW-2:0], ge};
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
            r_dz[s+1]  <= r_dz[s];
        end
    end

    assign q_low = r_rq[QW][DW-1:0];

    always_ff @(posedge i_clk) begin
        priority if (r_dz[QW]) begin
            r_res <= '0;
        end else if (r_neg[QW]) begin
            r_res <= DW'(-q_low);
        end else begin
            r_res <= q_low;
        end
        r_res_dz <= r_dz[QW];
    end

    qfa_dly #(.WIDTH(DW + 1), .DEPTH(LAT - OWN)) u_pad (
        .i_clk (i_clk),
        .i_d   ({r_res_dz, r_res}),
        .o_q   ({o_dz, o_q})
    );

endmodule

### rtl/core/qfa_f2x.sv
// Pipelined IEEE single to fixed-point converter, round half away from zero, saturating.
module qfa_f2x import qfa_pkg::*; #(
    parameter int DW  = 32,
    parameter int FB  = 8,
    parameter int LAT = 43
) (
    input  logic          i_clk,
    input  logic [31:0]   i_bits,
    output logic [DW-1:0] o_val,
    output logic          o_err
);

    localparam int OWN = 5;
    localparam logic [63:0] LIM_POS = (64'd1 << (DW - 1)) - 64'd1;

    // decode
    logic [7:0]        e_eff;
    logic              r1_sign, r1_nan, r1_inf;
    logic [23:0]       r1_m;
    logic signed [9:0] r1_sh;

    assign e_eff = (i_bits[30:23] == 8'd0) ? 8'd1 : i_bits[30:23];

    always_ff @(posedge i_clk) begin
        r1_sign <= i_bits[31];
        r1_nan  <= (i_bits[30:23] == FLT_EXP_SPECIAL) && (i_bits[22:0] != '0);
        r1_inf  <= (i_bits[30:23] == FLT_EXP_SPECIAL) && (i_bits[22:0] == '0);
        r1_m    <= {i_bits[30:23] != 8'd0, i_bits[22:0]};
        r1_sh   <= 10'(int'(e_eff) - FLT_EXP_OFFSET + FB);
    end

    // shift left, or add the rounding half for a right shift
    logic       left, big, tiny;
    logic [9:0] neg_sh;
    logic [4:0] k;
    logic [63:0] r2_val;
    logic [4:0]  r2_k;
    logic        r2_left, r2_big, r2_tiny, r2_sign, r2_nan, r2_inf;

    always_comb begin
        left   = !r1_sh[9];
        big    = left && (r1_sh > 10'(F2X_BIG_SHIFT));
        tiny   = !left && (r1_sh < -10'(F2X_TINY_SHIFT));
        neg_sh = 10'(-r1_sh);
        k      = neg_sh[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (left) begin
            r2_val <= 64'(r1_m) << r1_sh[5:0];
        end else begin
            r2_val <= 64'(25'(r1_m) + (25'd1 << (k - 5'd1)));
        end
        r2_k    <= k;
        r2_left <= left;
        r2_big  <= big;
        r2_tiny <= tiny;
        r2_sign <= r1_sign;
        r2_nan  <= r1_nan;
        r2_inf  <= r1_inf;
    end

    logic [63:0] r3_mag;
    logic        r3_big, r3_sign, r3_nan, r3_inf;

    always_ff @(posedge i_clk) begin
        priority if (r2_left) begin
            r3_mag <= r2_val;
        end else if (r2_tiny) begin
            r3_mag <= '0;
        end else begin
            r3_mag <= r2_val >> r2_k;
        end
        r3_big  <= r2_big;
        r3_sign <= r2_sign;
        r3_nan  <= r2_nan;
        r3_inf  <= r2_inf;
    end

    // saturate
    logic [63:0]   limit;
    logic          ovf;
    logic [DW-1:0] r4_mag;
    logic          r4_sign, r4_err;

    always_comb begin
        limit = LIM_POS + 64'(r3_sign);
        ovf   = r3_big || r3_inf || (r3_mag > limit);
    end

    always_ff @(posedge i_clk) begin
        priority if (r3_nan) begin
            r4_mag <= '0;
        end else if (ovf) begin
            r4_mag <= limit[DW-1:0];
        end else begin
            r4_mag <= r3_mag[DW-1:0];
        end
        r4_sign <= r3_sign;
        r4_err  <= r3_nan || ovf;
    end

    logic [DW-1:0] r5_val;
    logic          r5_err;

    always_ff @(posedge i_clk) begin
        r5_val <= r4_sign ? DW'(-r4_mag) : r4_mag;
        r5_err <= r4_err;
    end

    qfa_dly #(.WIDTH(DW + 1), .DEPTH(LAT - OWN)) u_pad (
        .i_clk (i_clk),
        .i_d   ({r5_err, r5_val}),
        .o_q   ({o_err, o_val})
    );

endmodule

### rtl/core/qfa_x2f.sv
// Pipelined fixed-point to IEEE single converter, round to nearest even.
module qfa_x2f import qfa_pkg::*; #(
    parameter int DW  = 32,
    parameter int FB  = 8,
    parameter int LAT = 43
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    output logic        [31:0]   o_bits
);

    localparam int NS  = $clog2(DW);
    localparam int OWN = NS + 3;

    logic [DW-1:0] r_n  [NS+1];
    logic [NS-1:0] r_lz [NS+1];
    logic          r_sg [NS+1];
    logic          r_zr [NS+1];

    always_ff @(posedge i_clk) begin
        r_n[0]  <= i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
        r_lz[0] <= '0;
        r_sg[0] <= i_a[DW-1];
        r_zr[0] <= (i_a == '0);
    end

    // normalize: halve the shift step each stage
    for (genvar s = 0; s < NS; s++) begin : g_norm
        localparam int AMT = 1 << (NS - 1 - s);

        always_ff @(posedge i_clk) begin
            if (r_n[s][DW-1 -: AMT] == '0) begin
                r_n[s+1]  <= r_n[s] << AMT;
                r_lz[s+1] <= r_lz[s] + NS'(AMT);
            end else begin
                r_n[s+1]  <= r_n[s];
                r_lz[s+1] <= r_lz[s];
            end
            r_sg[s+1] <= r_sg[s];
            r_zr[s+1] <= r_zr[s];
        end
    end

    logic [DW+23:0] ext;
    logic           half, sticky;
    logic [23:0]    r_q;
    logic           r_up, r_rsg, r_rzr;
    logic [6:0]     r_p;

    always_comb begin
        ext    = {r_n[NS], 24'd0};
        half   = ext[DW-1];
        sticky = |ext[DW-2:0];
    end

    always_ff @(posedge i_clk) begin
        r_q   <= ext[DW+23 -: 24];
        r_up  <= half && (sticky || ext[DW]);
        r_p   <= 7'(DW - 1) - 7'(r_lz[NS]);
        r_rsg <= r_sg[NS];
        r_rzr <= r_zr[NS];
    end

    logic [24:0] qs;
    logic [8:0]  e9;
    logic [31:0] r_bits;

    always_comb begin
        qs = 25'(r_q) + 25'(r_up);
        e9 = 9'(r_p) + 9'(qs[24]) + 9'(FLT_BIAS - FB);
    end

    always_ff @(posedge i_clk) begin
        if (r_rzr) begin
            r_bits <= '0;
        end else begin
            r_bits <= {r_rsg, e9[7:0], qs[24] ? 23'd0 : qs[22:0]};
        end
    end

    qfa_dly #(.WIDTH(32), .DEPTH(LAT - OWN)) u_pad (
        .i_clk (i_clk),
        .i_d   (r_bits),
        .o_q   (o_bits)
    );

endmodule

### rtl/core/q24_8_fixed_point_alu_top.sv
// Top level of the Q24.8 fixed-point ALU: input stage, parallel units, result select.
//
// Usage:
//   Drive i_action, i_operand_a and i_operand_b with start high; the word is
//   taken at that clock edge (busy is never raised, so one word can enter
//   every cycle).
//   Each word returns exactly one result word, in order, on o_result, the
//   compare flags and o_status, marked by o_valid for one cycle.
//   Throughput is one word per cycle. The divider resolves one quotient
//   bit per pipeline stage and is the deepest unit; every unit, the divider
//   included, is padded to the same common depth.
//   Reset (synchronous, active low) clears the valid line, so words in flight
//   are dropped and no result appears until new words are taken.
//   The receiver cannot stall: o_valid is a strobe and each result is shown
//   only in that cycle.
module q24_8_fixed_point_alu_top import qfa_pkg::*; #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic        [3:0]  i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    output logic signed [31:0] o_result,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic        [1:0]  o_status
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int LAT = DW + FB + 3;
    localparam int SW  = DW + 7;

    assign busy = 1'b0;

    // input stage
    logic                 r_vld0;
    logic [3:0]           r_act;
    logic signed [DW-1:0] r_a, r_b;
    logic [31:0]          r_araw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= i_action;
        r_a    <= i_operand_a[DW-1:0];
        r_b    <= i_operand_b[DW-1:0];
        r_araw <= i_operand_a;
    end

    // combinational operations and flags
    logic [DW-1:0] simple;
    logic          gt, lt, eq;

    always_comb begin
        gt = (r_a > r_b);
        lt = (r_a < r_b);
        eq = (r_a == r_b);
        unique case (t_action'(r_act))
            ACT_ADD:      simple = DW'(r_a + r_b);
            ACT_SUB:      simple = DW'(r_a - r_b);
            ACT_MIN:      simple = lt ? r_a : r_b;
            ACT_MAX:      simple = gt ? r_a : r_b;
            ACT_INC:      simple = DW'(r_a + 1);
            ACT_DEC:      simple = DW'(r_a - 1);
            ACT_FROM_INT: simple = DW'(r_a <<< FB);
            ACT_TO_INT:   simple = DW'(r_a >>> FB);
            default:      simple = '0;
        endcase
    end

    logic [SW-1:0] d_simple;
    logic [DW-1:0] d_val;
    logic          d_gt, d_lt, d_eq;
    logic [3:0]    d_act;

    qfa_dly #(.WIDTH(SW), .DEPTH(LAT)) u_simple (
        .i_clk (i_clk),
        .i_d   ({simple, gt, lt, eq, r_act}),
        .o_q   (d_simple)
    );

    assign {d_val, d_gt, d_lt, d_eq, d_act} = d_simple;

    logic [DW-1:0] mul_p, div_q, f2x_val;
    logic          div_dz, f2x_err;
    logic [31:0]   x2f_bits;

    qfa_mul #(.DW(DW), .FB(FB), .LAT(LAT)) u_mul (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_p   (mul_p)
    );

    qfa_div #(.DW(DW), .FB(FB), .LAT(LAT)) u_div (
        .i_clk (i_clk),
        .i_a   (r_a),
        .i_b   (r_b),
        .o_q   (div_q),
        .o_dz  (div_dz)
    );

    qfa_f2x #(.DW(DW), .FB(FB), .LAT(LAT)) u_f2x (
        .i_clk  (i_clk),
        .i_bits (r_araw),
        .o_val  (f2x_val),
        .o_err  (f2x_err)
    );

    qfa_x2f #(.DW(DW), .FB(FB), .LAT(LAT)) u_x2f (
        .i_clk  (i_clk),
        .i_a    (r_a),
        .o_bits (x2f_bits)
    );

    // valid line matches the unit latency
    logic [LAT-1:0] r_vld_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sh <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_vld_sh <= {r_vld_sh[LAT-2:0], r_vld0};
            o_valid  <= r_vld_sh[LAT-1];
        end
    end

    logic [31:0] n_result;
    t_status     n_status;

    always_comb begin
        unique case (t_action'(d_act))
            ACT_MUL: begin
                n_result = 32'($signed(mul_p));
                n_status = ST_OK;
            end
            ACT_DIV: begin
                n_result = 32'($signed(div_q));
                n_status = div_dz ? ST_DIV_ZERO : ST_OK;
            end
            ACT_FROM_FLOAT: begin
                n_result = 32'($signed(f2x_val));
                n_status = f2x_err ? ST_FLOAT_RANGE : ST_OK;
            end
            ACT_TO_FLOAT: begin
                n_result = x2f_bits;
                n_status = ST_OK;
            end
            default: begin
                n_result = 32'($signed(d_val));
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_result    <= n_result;
        o_status    <= n_status;
        o_a_greater <= d_gt;
        o_a_less    <= d_lt;
        o_a_equal   <= d_eq;
    end

endmodule
